// ===== rtl/aup_pkg.sv =====
// aup_pkg: shared types and constants for the alpha un-premultiply pipeline
// no dependencies; imported by every module in rtl/
package aup_pkg;

  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned DIV_STAGES = 4;
  localparam logic [7:0]  CHAN_MAX   = 8'hFF;

  // per-request payload carried down the divider stages
  // channel index 0 is red, 1 green, 2 blue
  typedef struct packed {
    logic [7:0]                 alpha;
    logic                       pass;   // alpha zero or full: colours unchanged
    logic [NUM_CHAN-1:0]        sat;    // channel not below alpha: result is full scale
    logic [NUM_CHAN-1:0][7:0]   orig;   // colour value as received
    logic [NUM_CHAN-1:0][15:0]  rem;    // running remainder of the rounded numerator
    logic [NUM_CHAN-1:0][7:0]   quo;    // quotient bits found so far
    logic [14:0]                dvs;    // alpha aligned to the next quotient bit
  } aup_stage_t;

endpackage

// ===== rtl/alpha_unpremultiply_pixel.sv =====
// alpha_unpremultiply_pixel: top level of the premultiplied ARGB to straight RGBA pipeline
// depends on aup_pkg, aup_prep and aup_div_stage
//
// Usage
//   input channel : in_valid / in_ready / in_pixel_argb, one premultiplied pixel
//                   per request, alpha in bits 31-24 and blue in bits 7-0
//   output channel: out_valid / out_ready / out_pixel_rgba, one straight-alpha
//                   pixel per request, red in bits 7-0 and alpha in bits 31-24
//   each colour becomes round(c*255/alpha) when alpha is strictly between 0 and
//   255, passes unchanged when alpha is 0 or 255, and clamps to 255 when the
//   colour is not below alpha
//   pipeline: six pipeline registers (numerator stage, four two-bit divider
//   stages, output register), the first of which loads at the accepting edge
//   throughput: one pixel per clock unless stalled; pixels are independent
//   stall: when out_valid is high and out_ready low, every stage holds and
//   in_ready drops in the same cycle, so nothing is lost or repeated
//   reset: synchronous active-low rst_n clears all valid bits; the pipeline
//   comes out of reset empty and ready
module alpha_unpremultiply_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel_argb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_rgba
);
  import aup_pkg::*;

  logic        en;
  logic        out_valid_r;
  logic [31:0] out_pixel_r;
  logic [31:0] out_pixel_nxt;

  logic       [DIV_STAGES:0] stg_valid;
  aup_stage_t [DIV_STAGES:0] stg;

  // whole pipeline advances unless the output holds an untaken request
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  aup_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_pixel_argb (in_pixel_argb),
    .valid_r       (stg_valid[0]),
    .stage_r       (stg[0])
  );

  // divider chain, most significant quotient bits first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    aup_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (stg_valid[s]),
      .in_stage (stg[s]),
      .valid_r  (stg_valid[s+1]),
      .stage_r  (stg[s+1])
    );
  end

  // select pass-through, clamp or quotient and repack
  always_comb begin
    logic [NUM_CHAN-1:0][7:0] chan;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      if (stg[DIV_STAGES].pass) begin
        chan[ch] = stg[DIV_STAGES].orig[ch];
      end else if (stg[DIV_STAGES].sat[ch]) begin
        chan[ch] = CHAN_MAX;
      end else begin
        chan[ch] = stg[DIV_STAGES].quo[ch];
      end
    end
    out_pixel_nxt = {stg[DIV_STAGES].alpha, chan[2], chan[1], chan[0]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_rgba = out_pixel_r;

endmodule

// ===== rtl/aup_prep.sv =====
// aup_prep: first pipeline stage, splits the pixel and forms the rounded numerators
// depends on aup_pkg
module aup_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        in_pixel_argb,
  output logic               valid_r,
  output aup_pkg::aup_stage_t stage_r
);
  import aup_pkg::*;

  aup_stage_t stage_nxt;
  logic [7:0] alpha;

  assign alpha = in_pixel_argb[31:24];

  // numerator c*255 + alpha/2, plus special-case flags
  always_comb begin
    stage_nxt       = '0;
    stage_nxt.alpha = alpha;
    stage_nxt.pass  = (alpha == 8'h00) || (alpha == CHAN_MAX);
    stage_nxt.orig[0] = in_pixel_argb[23:16];
    stage_nxt.orig[1] = in_pixel_argb[15:8];
    stage_nxt.orig[2] = in_pixel_argb[7:0];
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      stage_nxt.sat[ch] = (stage_nxt.orig[ch] >= alpha);
      stage_nxt.rem[ch] = {stage_nxt.orig[ch], 8'h00} - {8'h00, stage_nxt.orig[ch]}
                        + {9'h000, alpha[7:1]};
      stage_nxt.quo[ch] = 8'h00;
    end
    stage_nxt.dvs = {alpha, 7'h00};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== rtl/aup_div_stage.sv =====
// aup_div_stage: one restoring-division stage, two quotient bits for all three channels
// depends on aup_pkg
module aup_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  aup_pkg::aup_stage_t in_stage,
  output logic                valid_r,
  output aup_pkg::aup_stage_t stage_r
);
  import aup_pkg::*;

  aup_stage_t          stage_nxt;
  logic [15:0]         dvs_hi;
  logic [15:0]         dvs_lo;
  logic [NUM_CHAN-1:0] bit_hi;
  logic [NUM_CHAN-1:0] bit_lo;
  logic [NUM_CHAN-1:0][15:0] rem_mid;

  assign dvs_hi = {1'b0, in_stage.dvs};
  assign dvs_lo = {2'b00, in_stage.dvs[14:1]};

  // two compare-and-subtract steps per channel
  always_comb begin
    stage_nxt = in_stage;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      bit_hi[ch]  = (in_stage.rem[ch] >= dvs_hi);
      rem_mid[ch] = bit_hi[ch] ? (in_stage.rem[ch] - dvs_hi) : in_stage.rem[ch];
      bit_lo[ch]  = (rem_mid[ch] >= dvs_lo);
      stage_nxt.rem[ch] = bit_lo[ch] ? (rem_mid[ch] - dvs_lo) : rem_mid[ch];
      stage_nxt.quo[ch] = {in_stage.quo[ch][5:0], bit_hi[ch], bit_lo[ch]};
    end
    stage_nxt.dvs = {2'b00, in_stage.dvs[14:2]};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== tb/tb_alpha_unpremultiply_pixel.sv =====
// testbench for alpha_unpremultiply_pixel: premultiplied ARGB in, straight RGBA out
// depends on aup_pkg and the alpha_unpremultiply_pixel RTL; a scoreboard class predicts
// every result, plain tasks drive the valid/ready channels with random idling
`timescale 1ns / 1ps

module tb_alpha_unpremultiply_pixel;
  import aup_pkg::*;

  // expected straight-alpha pixels, one per accepted request, in order
  class unpremul_scoreboard;
    logic [31:0] straight_q[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    // rounded c*255/a, colours pass at alpha zero or full, clamp at full scale
    function logic [7:0] unpremul_chan(logic [7:0] c, logic [7:0] a);
      int unsigned q;
      if (a == 8'd0 || a == CHAN_MAX) begin
        return c;
      end
      q = (int'(c) * int'(CHAN_MAX) + int'(a >> 1)) / int'(a);
      return (q > int'(CHAN_MAX)) ? CHAN_MAX : q[7:0];
    endfunction

    function logic [31:0] unpremultiply(logic [31:0] argb);
      logic [7:0] a;
      a = argb[31:24];
      return {a, unpremul_chan(argb[7:0], a), unpremul_chan(argb[15:8], a),
              unpremul_chan(argb[23:16], a)};
    endfunction

    function void note_pixel(logic [31:0] argb);
      straight_q.push_back(unpremultiply(argb));
    endfunction

    function void check_pixel(logic [31:0] rgba);
      logic [31:0] want;
      if (straight_q.size() == 0) begin
        $error("pixel_rgba: result with no request outstanding, actual %08h", rgba);
        fail_count++;
        return;
      end
      want = straight_q.pop_front();
      if (rgba !== want) begin
        $error("pixel_rgba: expected %08h, actual %08h", want, rgba);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return straight_q.size();
    endfunction

    function void report_leftover();
      if (straight_q.size() != 0) begin
        $error("pixel_rgba: %0d expected results never arrived", straight_q.size());
        fail_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_pixel_argb;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pixel_rgba;

  unpremul_scoreboard sb;
  bit sink_hold;     // ask the sink for one long hold-off
  bit idle_off;      // stretch with no idling on either side

  alpha_unpremultiply_pixel i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_argb (in_pixel_argb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_rgba(out_pixel_rgba)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_off) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // alpha biased to the special values, colours mostly well formed
  function automatic logic [31:0] random_pixel();
    logic [7:0] a;
    logic [7:0] ch [3];
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      a = 8'd0;
    end else if (sel < 20) begin
      a = 8'd255;
    end else if (sel < 28) begin
      case ($urandom_range(0, 2))
        0: a = 8'd1;
        1: a = 8'd2;
        default: a = 8'd254;
      endcase
    end else begin
      a = 8'($urandom_range(1, 254));
    end
    for (int i = 0; i < 3; i++) begin
      if (a != 8'd0 && a != 8'd255 && $urandom_range(0, 99) < 85) begin
        ch[i] = 8'($urandom_range(0, a));
      end else begin
        ch[i] = 8'($urandom);
      end
    end
    return {a, ch[0], ch[1], ch[2]};
  endfunction

  // offer one request after a gap, return at the edge where it is taken
  task automatic send_pixel(input logic [31:0] px);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_argb <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_pixel());
    end
  endtask

  // pause until every outstanding result has come back
  // one edge first so the last accepted request is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // note accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_pixel(in_pixel_argb);
      end
      if (out_valid && out_ready) begin
        sb.check_pixel(out_pixel_rgba);
      end
    end
  end

  // result sink: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned r;
    int unsigned n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        sink_hold = 1'b0;
      end else if (idle_off) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else if (r < 36) begin
          out_ready <= 1'b0;
          n = $urandom_range(10, 30);
        end else begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 8);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // main sequence
  initial begin
    logic [31:0] directed [20];
    sb            = new();
    sink_hold     = 1'b0;
    idle_off      = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_pixel_argb <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alpha zero with nonzero colours, alpha full, rounding, channel above alpha
    directed = '{32'h00FF8001, 32'h00000000, 32'hFFFF0080, 32'hFFFFFFFF,
                 32'h01000100, 32'h0101FF01, 32'h02010200, 32'h02FF0102,
                 32'h80407F80, 32'h8081FF00, 32'hFEFDFEFF, 32'hFE00017F,
                 32'h7F3F7F00, 32'h7F407E01, 32'h55AA5555, 32'hAA55AAAB,
                 32'h03010203, 32'hFD7E7F80, 32'h40204000, 32'h7FFFFFFF};
    foreach (directed[i]) begin
      send_pixel(directed[i]);
    end

    // random with idling on both sides
    send_random(200);

    // sink holds off while requests keep coming, so the pipeline fills
    sink_hold = 1'b1;
    idle_off  = 1'b1;
    send_random(40);
    idle_off  = 1'b0;
    in_valid <= 1'b0;
    wait_drained();

    // back to back with no idling
    idle_off = 1'b1;
    send_random(80);
    idle_off = 1'b0;

    // random tail
    send_random(230);
    in_valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    sb.report_leftover();
    if (sb.fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aup_pkg.sv
rtl/aup_prep.sv
rtl/aup_div_stage.sv
rtl/alpha_unpremultiply_pixel.sv
tb/tb_alpha_unpremultiply_pixel.sv
